// File: hdl/wsd_pkg.sv
// Package for the work-stealing deque: depth, index widths and operation codes.
// Depends on nothing; used by hdl/work_stealing_deque.sv.
package wsd_pkg;

	// Number of handle slots in the store
	localparam int unsigned DEPTH  = 256;
	// Slot address width and index width (an index also holds DEPTH itself)
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned IDX_W  = $clog2(DEPTH + 1);
	localparam int unsigned JOB_W  = 32;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [JOB_W-1:0]  job_t;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_STEAL = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

endpackage

// File: hdl/work_stealing_deque.sv
// Bounded, non-wrapping work-stealing deque of 32-bit job handles.
// Depends on hdl/wsd_pkg.sv for depth, widths and operation codes.
//
//  channel   | ports                              | transaction
//  ----------+------------------------------------+-----------------------------
//  request   | start, busy, kind, job_handle      | start high while busy low
//  result    | done, success, job_out, empty_after| done high for one cycle
//
// Each request is taken as soon as it is offered; its result appears on the cycle
// after, from the registered read of the slot memory. A new request may be
// taken every cycle, so busy stays low. Index updates and slot writes happen
// at the accepting edge, so a later read of the same slot always sees the data.
// Reset clears both indices and the result strobe; the slot memory is not
// cleared. The receiver cannot stall the result.
module work_stealing_deque (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [31:0]         job_handle,
	output logic                done,
	output logic                success,
	output logic [31:0]         job_out,
	output logic                empty_after
);

	// Slot store, read and written at one address each cycle
	wsd_pkg::job_t mem [wsd_pkg::DEPTH];

	wsd_pkg::idx_t  top_q, bot_q;
	wsd_pkg::idx_t  top_d, bot_d;
	wsd_pkg::kind_t op;
	logic           accept;
	logic           wr_en, rd_en, ok;
	wsd_pkg::addr_t addr;
	wsd_pkg::idx_t  nb;
	wsd_pkg::job_t  rdata_s1;
	logic           done_s1, ok_s1, rd_s1, empty_s1;

	localparam wsd_pkg::idx_t DEPTH_IDX = wsd_pkg::IDX_W'(wsd_pkg::DEPTH);

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op     = wsd_pkg::kind_t'(kind);
	assign nb     = bot_q - wsd_pkg::IDX_W'(1);

	// Decode the operation against the current indices
	always_comb begin
		top_d = top_q;
		bot_d = bot_q;
		wr_en = 1'b0;
		rd_en = 1'b0;
		ok    = 1'b0;
		addr  = bot_q[wsd_pkg::ADDR_W-1:0];
		case (op)
			wsd_pkg::KIND_PUSH: begin
				if (bot_q < DEPTH_IDX) begin
					wr_en = accept;
					ok    = 1'b1;
					bot_d = bot_q + wsd_pkg::IDX_W'(1);
				end
			end
			wsd_pkg::KIND_POP: begin
				if (bot_q > top_q && bot_q <= DEPTH_IDX) begin
					rd_en = accept;
					ok    = 1'b1;
					addr  = nb[wsd_pkg::ADDR_W-1:0];
					if (nb == top_q) begin
						top_d = bot_q;
					end else begin
						bot_d = nb;
					end
				end else begin
					top_d = '0;
					bot_d = '0;
				end
			end
			wsd_pkg::KIND_STEAL: begin
				if (top_q < bot_q && top_q < DEPTH_IDX) begin
					rd_en = accept;
					ok    = 1'b1;
					addr  = top_q[wsd_pkg::ADDR_W-1:0];
					top_d = top_q + wsd_pkg::IDX_W'(1);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Write on push, registered read on pop and steal
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= job_handle;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

	// Advance indices on each accepted request and register the result strobe and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bot_q    <= '0;
			done_s1  <= 1'b0;
			ok_s1    <= 1'b0;
			rd_s1    <= 1'b0;
			empty_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				top_q    <= top_d;
				bot_q    <= bot_d;
				ok_s1    <= ok;
				rd_s1    <= rd_en;
				empty_s1 <= (top_d == bot_d);
			end
		end
	end

	assign done        = done_s1;
	assign success     = ok_s1;
	assign job_out     = rd_s1 ? rdata_s1 : '0;
	assign empty_after = empty_s1;

	// Top never passes bottom
	a_order: assert property (@(posedge clk) disable iff (!arst_n) top_q <= bot_q)
		else $error("top index above bottom index");

	// Bottom never passes the depth
	a_bound: assert property (@(posedge clk) disable iff (!arst_n) bot_q <= DEPTH_IDX)
		else $error("bottom index beyond depth");

	// Every accepted request yields a strobe on the next cycle
	a_done: assert property (@(posedge clk) disable iff (!arst_n) accept |=> done)
		else $error("result strobe missing after accept");

	// A failed operation returns no handle
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !success) |-> (job_out == '0))
		else $error("handle returned on failed operation");

	// A push never reads the store
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == wsd_pkg::KIND_PUSH) |-> !rd_en)
		else $error("read issued on push");

endmodule
